FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable and a custom message
`define ASSERT_CLK_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked assertion with a generic message
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  `ASSERT_CLK_MSG(lbl, clk, rstn, prop, "assertion failed")

`endif

FILE: rtl/core/bdim_pkg.sv
// types, widths and constants of the barrel distortion inverse mapper
// no dependencies
package bdim_pkg;

  localparam int FRAC_BITS      = 20;
  localparam int ITER_LIMIT     = 10;
  localparam int BEND_FRAC      = 16;

  localparam int PT_W   = 13;
  localparam int CEN_W  = 11;
  localparam int BEND_W = 20;
  localparam int PIX_W  = 12;
  localparam int APB_AW = 4;

  // offset magnitude, estimate magnitude and derived widths
  localparam int OFF_W     = PT_W;
  localparam int MAG_W     = OFF_W + FRAC_BITS;
  localparam int N_W       = MAG_W + 1;
  localparam int DVD_W     = MAG_W + FRAC_BITS;
  localparam int R_W       = 2 * MAG_W - FRAC_BITS + 1;
  localparam int FAC_W     = BEND_W + R_W - BEND_FRAC + 1;
  localparam int MUL_W     = ((R_W + 7) / 8) * 8;
  localparam int MUL_STEPS = MUL_W / 8;
  localparam int ITER_W    = $clog2(ITER_LIMIT + 1);

  localparam longint EPS = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;

  localparam logic [APB_AW-3:0] REG_CENTER_X = 2'd0;
  localparam logic [APB_AW-3:0] REG_CENTER_Y = 2'd1;
  localparam logic [APB_AW-3:0] REG_BEND     = 2'd2;

  typedef enum logic [1:0] {
    SEL_SQX,
    SEL_SQY,
    SEL_BEND
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     div_norm;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     update;
    logic     push;
    logic     early;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic converged;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: rtl/core/bdim_mul.sv
// iterative multiplier, eight multiplier bits per cycle, msb first
// depends on bdim_pkg
module bdim_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [bdim_pkg::MUL_W-1:0]          a_i,
  input  logic [bdim_pkg::MUL_W-1:0]          b_i,
  output logic [2*bdim_pkg::MUL_W-1:0]        prod_o,
  output logic                                done_o
);
  import bdim_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS + 1);

  logic [MUL_W-1:0]   a_q, b_q;
  logic [2*MUL_W-1:0] acc_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;
  logic [MUL_W+7:0]   pp;

  assign pp = a_q * b_q[MUL_W-1 -: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(MUL_STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= (acc_q << 8) + (2*MUL_W)'(pp);
      b_q   <= b_q << 8;
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

FILE: rtl/core/bdim_div.sv
// restoring divider, one quotient bit per cycle
// depends on bdim_pkg; the quotient must fit in MAG_W bits
module bdim_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bdim_pkg::DVD_W-1:0]    dividend_i,
  input  logic [bdim_pkg::FAC_W-1:0]    divisor_i,
  output logic [bdim_pkg::MAG_W-1:0]    quot_o,
  output logic                          done_o
);
  import bdim_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [FAC_W-1:0] rem_q, div_q;
  logic [MAG_W-1:0] dq_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [FAC_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_q, dq_q[MAG_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(MAG_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= FAC_W'(dividend_i[DVD_W-1:MAG_W]);
      dq_q  <= dividend_i[MAG_W-1:0];
      div_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[FAC_W-1:0] : trial[FAC_W-1:0];
      dq_q  <= {dq_q[MAG_W-2:0], ge};
    end
  end

  assign quot_o = dq_q;
  assign done_o = done_q;

endmodule

FILE: rtl/core/bdim_dp.sv
// datapath: offsets, estimates, shared multiplier, two dividers, output register
// depends on bdim_pkg, bdim_mul, bdim_div
module bdim_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bdim_pkg::dp_cmd_t                   cmd_i,
  output bdim_pkg::dp_status_t                status_o,
  input  logic signed [bdim_pkg::PT_W-1:0]    point_x_i,
  input  logic signed [bdim_pkg::PT_W-1:0]    point_y_i,
  input  logic [bdim_pkg::CEN_W-1:0]          center_x_i,
  input  logic [bdim_pkg::CEN_W-1:0]          center_y_i,
  input  logic [bdim_pkg::BEND_W-1:0]         bend_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [bdim_pkg::PIX_W-1:0]          mapped_x_o,
  output logic [bdim_pkg::PIX_W-1:0]          mapped_y_o,
  output logic                                early_o
);
  import bdim_pkg::*;

  localparam logic [FAC_W-1:0]      ONE_FAC = FAC_W'(1) << FRAC_BITS;
  localparam logic signed [N_W:0]   EPS_S   = (N_W+1)'(EPS);
  localparam logic signed [N_W:0]   ONE_S   = (N_W+1)'(1) << FRAC_BITS;
  localparam int                    V_W     = N_W + CEN_W + 2;

  function automatic logic signed [N_W-1:0] apply_sign(input logic neg,
                                                       input logic [MAG_W-1:0] mag);
    logic signed [N_W-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [N_W-1:0] v);
    logic [N_W-1:0] t;
    t = v[N_W-1] ? N_W'(0) - v : v;
    return t[MAG_W-1:0];
  endfunction

  function automatic logic close_enough(input logic signed [N_W-1:0] a,
                                        input logic signed [N_W-1:0] b);
    logic signed [N_W:0] d;
    d = $signed({a[N_W-1], a}) - $signed({b[N_W-1], b});
    return (d < EPS_S) && (d > -EPS_S);
  endfunction

  function automatic logic [PIX_W-1:0] to_pixel(input logic signed [N_W-1:0] n,
                                                input logic [CEN_W-1:0] c);
    logic signed [N_W:0]   s;
    logic signed [V_W-1:0] v;
    logic [V_W-FRAC_BITS-1:0] px, lim;
    s   = ONE_S + $signed({n[N_W-1], n});
    v   = $signed({1'b0, c}) * s;
    px  = v[V_W-1:FRAC_BITS];
    lim = (V_W-FRAC_BITS)'({c, 1'b0});
    if (v[V_W-1]) return '0;
    else if (px > lim) return PIX_W'(lim);
    else return px[PIX_W-1:0];
  endfunction

  // centre of zero acts as one
  logic [CEN_W-1:0] cx, cy;
  assign cx = (center_x_i == '0) ? CEN_W'(1) : center_x_i;
  assign cy = (center_y_i == '0) ? CEN_W'(1) : center_y_i;

  logic signed [OFF_W:0] offx, offy;
  logic [OFF_W:0]        offx_abs, offy_abs;
  assign offx     = $signed({point_x_i[PT_W-1], point_x_i})
                  - $signed({{(OFF_W+1-CEN_W){1'b0}}, cx});
  assign offy     = $signed({point_y_i[PT_W-1], point_y_i})
                  - $signed({{(OFF_W+1-CEN_W){1'b0}}, cy});
  assign offx_abs = offx[OFF_W] ? (OFF_W+1)'(0) - offx : offx;
  assign offy_abs = offy[OFF_W] ? (OFF_W+1)'(0) - offy : offy;

  logic [OFF_W-1:0]      offx_mag_q, offy_mag_q;
  logic                  offx_neg_q, offy_neg_q;
  logic [MAG_W-1:0]      dx_mag_q, dy_mag_q;
  logic                  dx_neg_q, dy_neg_q;
  logic signed [N_W-1:0] nx_q, ny_q, nxn_q, nyn_q;
  logic [R_W-1:0]        sqx_q, r_q;
  logic [FAC_W-1:0]      fac_q;
  mul_sel_e              mul_tag_q;
  logic                  div_norm_q;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic               mul_done;
  logic [MAG_W-1:0]   ax, ay;

  assign ax = mag_of(nx_q);
  assign ay = mag_of(ny_q);

  always_comb begin
    case (cmd_i.mul_sel)
      SEL_SQX: begin
        mul_a = MUL_W'(ax);
        mul_b = MUL_W'(ax);
      end
      SEL_SQY: begin
        mul_a = MUL_W'(ay);
        mul_b = MUL_W'(ay);
      end
      SEL_BEND: begin
        mul_a = MUL_W'(r_q);
        mul_b = MUL_W'(bend_i);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bdim_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  // two dividers, one per axis, sharing start and length
  logic [DVD_W-1:0] dvd_x, dvd_y;
  logic [FAC_W-1:0] dvs_x, dvs_y;
  logic [MAG_W-1:0] qx, qy;
  logic             div_done, div_done_y;

  assign dvd_x = cmd_i.div_norm ? DVD_W'({offx_mag_q, {FRAC_BITS{1'b0}}})
                                : {dx_mag_q, {FRAC_BITS{1'b0}}};
  assign dvd_y = cmd_i.div_norm ? DVD_W'({offy_mag_q, {FRAC_BITS{1'b0}}})
                                : {dy_mag_q, {FRAC_BITS{1'b0}}};
  assign dvs_x = cmd_i.div_norm ? FAC_W'(cx) : fac_q;
  assign dvs_y = cmd_i.div_norm ? FAC_W'(cy) : fac_q;

  bdim_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_x),
    .divisor_i  (dvs_x),
    .quot_o     (qx),
    .done_o     (div_done)
  );

  bdim_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_y),
    .divisor_i  (dvs_y),
    .quot_o     (qy),
    .done_o     (div_done_y)
  );

  // tiny offsets are forced to epsilon, zero goes negative
  logic             tiny_x, tiny_y, dxn_neg, dyn_neg;
  logic [MAG_W-1:0] dxn_mag, dyn_mag;
  assign tiny_x  = qx < MAG_W'(EPS);
  assign tiny_y  = qy < MAG_W'(EPS);
  assign dxn_mag = tiny_x ? MAG_W'(EPS) : qx;
  assign dyn_mag = tiny_y ? MAG_W'(EPS) : qy;
  assign dxn_neg = tiny_x ? !(!offx_neg_q && (qx != '0)) : offx_neg_q;
  assign dyn_neg = tiny_y ? !(!offy_neg_q && (qy != '0)) : offy_neg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      offx_mag_q <= offx_abs[OFF_W-1:0];
      offy_mag_q <= offy_abs[OFF_W-1:0];
      offx_neg_q <= offx[OFF_W];
      offy_neg_q <= offy[OFF_W];
    end
    if (cmd_i.mul_start) mul_tag_q <= cmd_i.mul_sel;
    if (cmd_i.div_start) div_norm_q <= cmd_i.div_norm;
    if (mul_done) begin
      case (mul_tag_q)
        SEL_SQX:  sqx_q <= prod[FRAC_BITS +: R_W];
        SEL_SQY:  r_q   <= sqx_q + prod[FRAC_BITS +: R_W];
        SEL_BEND: fac_q <= ONE_FAC + prod[BEND_FRAC +: FAC_W];
        default:  ;
      endcase
    end
    if (div_done && div_done_y) begin
      if (div_norm_q) begin
        dx_mag_q <= dxn_mag;
        dy_mag_q <= dyn_mag;
        dx_neg_q <= dxn_neg;
        dy_neg_q <= dyn_neg;
        nx_q     <= apply_sign(dxn_neg, dxn_mag);
        ny_q     <= apply_sign(dyn_neg, dyn_mag);
      end else begin
        nxn_q <= apply_sign(dx_neg_q, qx);
        nyn_q <= apply_sign(dy_neg_q, qy);
      end
    end
    if (cmd_i.update) begin
      nx_q <= nxn_q;
      ny_q <= nyn_q;
    end
  end

  // output register
  logic             out_valid_q, early_q;
  logic [PIX_W-1:0] mx_q, my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mx_q    <= to_pixel(nx_q, cx);
      my_q    <= to_pixel(ny_q, cy);
      early_q <= cmd_i.early;
    end
  end

  assign status_o.mul_done  = mul_done;
  assign status_o.div_done  = div_done;
  assign status_o.converged = close_enough(nxn_q, nx_q) && close_enough(nyn_q, ny_q);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign mapped_x_o  = mx_q;
  assign mapped_y_o  = my_q;
  assign early_o     = early_q;

endmodule

FILE: rtl/core/bdim_ctrl.sv
// controller: sequences normalization, iterations and result hand-off
// depends on bdim_pkg
module bdim_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bdim_pkg::dp_status_t  status_i,
  output bdim_pkg::dp_cmd_t     cmd_o
);
  import bdim_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_NGO   = 12'b0000_0000_0010,
    S_NWAIT = 12'b0000_0000_0100,
    S_SQGO  = 12'b0000_0000_1000,
    S_SQX   = 12'b0000_0001_0000,
    S_SQY   = 12'b0000_0010_0000,
    S_BGO   = 12'b0000_0100_0000,
    S_BEND  = 12'b0000_1000_0000,
    S_DGO   = 12'b0001_0000_0000,
    S_DIV   = 12'b0010_0000_0000,
    S_CHK   = 12'b0100_0000_0000,
    S_PIX   = 12'b1000_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              early_q, early_d;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    early_d = early_q;
    cmd_o   = '0;
    cmd_o.mul_sel = SEL_SQX;
    cmd_o.early   = early_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          iter_d     = '0;
          early_d    = 1'b0;
          state_d    = S_NGO;
        end
      end
      S_NGO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_norm  = 1'b1;
        state_d         = S_NWAIT;
      end
      S_NWAIT: begin
        cmd_o.div_norm = 1'b1;
        if (status_i.div_done) state_d = S_SQGO;
      end
      S_SQGO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_SQX;
        state_d         = S_SQX;
      end
      S_SQX: begin
        if (status_i.mul_done) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = SEL_SQY;
          state_d         = S_SQY;
        end
      end
      S_SQY: begin
        if (status_i.mul_done) state_d = S_BGO;
      end
      S_BGO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = SEL_BEND;
        state_d         = S_BEND;
      end
      S_BEND: begin
        if (status_i.mul_done) state_d = S_DGO;
      end
      S_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_CHK;
      end
      S_CHK: begin
        if (status_i.converged) begin
          early_d = 1'b1;
          state_d = S_PIX;
        end else begin
          cmd_o.update = 1'b1;
          if (iter_q == ITER_W'(ITER_LIMIT - 1)) begin
            state_d = S_PIX;
          end else begin
            iter_d  = iter_q + 1'b1;
            state_d = S_SQGO;
          end
        end
      end
      S_PIX: begin
        if (!status_i.out_busy) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
      early_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      early_q <= early_d;
    end
  end

endmodule

FILE: rtl/core/barrel_distortion_inverse_map.sv
// each item runs a normalization division, then k iterations (1..10) of squares, bend
// factor and division, then the output hand-off; one item at a time
// a new item is taken only after the last result is pushed, later while a result waits to be taken;
// the dividers and the shared 8-bit-per-cycle multiplier set the iteration length
// reset: asynchronous active low, registers return to centre 640/360, bend 13107
// depends on bdim_pkg, bdim_ctrl, bdim_dp
module barrel_distortion_inverse_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // point_x[12:0], point_y[25:13]
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // mapped_x[11:0], mapped_y[23:12]
  output logic                           m_axis_tuser,  // converged_early
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bdim_pkg::APB_AW-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import bdim_pkg::*;

  // configuration registers
  logic [CEN_W-1:0]  center_x_q, center_y_q;
  logic [BEND_W-1:0] bend_q;
  logic [APB_AW-3:0] reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CEN_W'(640);
      center_y_q <= CEN_W'(360);
      bend_q     <= BEND_W'(13107);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CENTER_X: center_x_q <= pwdata[CEN_W-1:0];
        REG_CENTER_Y: center_y_q <= pwdata[CEN_W-1:0];
        REG_BEND:     bend_q     <= pwdata[BEND_W-1:0];
        default:      ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X: prdata = 32'(center_x_q);
      REG_CENTER_Y: prdata = 32'(center_y_q);
      REG_BEND:     prdata = 32'(bend_q);
      default:      prdata = '0;
    endcase
  end

  // control and datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  bdim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bdim_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .point_x_i   (s_axis_tdata[PT_W-1:0]),
    .point_y_i   (s_axis_tdata[2*PT_W-1:PT_W]),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .bend_i      (bend_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .mapped_x_o  (m_axis_tdata[PIX_W-1:0]),
    .mapped_y_o  (m_axis_tdata[2*PIX_W-1:PIX_W]),
    .early_o     (m_axis_tuser)
  );

endmodule

FILE: rtl/core/bdim_checker.sv
// port-level checks of the barrel distortion inverse mapper, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module bdim_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [23:0]                  m_axis_tdata
);

  // a pending result stays until taken
  `ASSERT_CLK(out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)

  // the block is busy right after taking an item
  `ASSERT_CLK(busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

  // no result appears in the cycle right after an input transaction
  `ASSERT_CLK(no_instant_out, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))

  // clamped coordinates never reach the all-ones code
  `ASSERT_CLK(clamp_range, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[11:0] != 12'hfff) && (m_axis_tdata[23:12] != 12'hfff))

endmodule

bind barrel_distortion_inverse_map bdim_checker u_bdim_checker (.*);
